### rtl/life_automaton_row_step_unit_assert.svh
// Assertion macros shared by the checker files of the row step unit.
// LRS_ASSERT: checked only while reset is released.
// LRS_ASSERT_RST: checked at every edge, reset included.
`ifndef LIFE_AUTOMATON_ROW_STEP_UNIT_ASSERT_SVH
`define LIFE_AUTOMATON_ROW_STEP_UNIT_ASSERT_SVH
`define LRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LRS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types, constants and the B3/S23 row update for the row step unit.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int COLS   = 64;               // widest grid row
  localparam int CNT_W  = 7;                // column count register width
  localparam int QDEPTH = 2;                // entries between front and back
  localparam int QA_W   = $clog2(QDEPTH);

  typedef logic [COLS-1:0]  row_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One queued request: three rows for the first result, done flag of that
  // result, and whether a second (final row) result follows.
  typedef struct packed {
    row_t above;
    row_t here;
    row_t below;
    logic done;
    logic second;
  } job_t;

  // Active column mask, count clamped to COLS.
  function automatic row_t active_mask(input cnt_t n);
    row_t m;
    if (n >= cnt_t'(COLS)) begin
      m = '1;
    end else begin
      m = (row_t'(1) << n) - row_t'(1);
    end
    return m;
  endfunction

  // Next generation of row h with neighbor rows a and b; outside is dead.
  function automatic row_t next_gen(input row_t a, input row_t h, input row_t b,
                                    input row_t mask);
    logic [COLS+1:0] ap;
    logic [COLS+1:0] hp;
    logic [COLS+1:0] bp;
    logic [3:0]      n;
    row_t            r;
    ap = {1'b0, a, 1'b0};
    hp = {1'b0, h, 1'b0};
    bp = {1'b0, b, 1'b0};
    for (int c = 0; c < COLS; c++) begin
      n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
        + 4'(hp[c]) + 4'(hp[c+2])
        + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
      r[c] = (n == 4'd3) || (h[c] && (n == 4'd2));
    end
    return r & mask;
  endfunction

endpackage

### rtl/lrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_front
// Accepts rows, keeps the two rows in flight and queues result requests.
// ----------------------------------------------------------------------------
module lrs_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           q_full,
  input  lrs_pkg::row_t  in_row_bits,
  input  logic           in_last_row,
  input  lrs_pkg::row_t  mask,
  output logic           job_push,
  output lrs_pkg::job_t  job
);

  logic          held_r, held_nxt;
  lrs_pkg::row_t prev_r, prev_nxt;
  lrs_pkg::row_t mid_r, mid_nxt;
  lrs_pkg::row_t cur;
  logic          acc;

  assign acc = push && !q_full;
  assign cur = in_row_bits & mask;

  // classify the row and update the row window
  always_comb begin
    held_nxt = held_r;
    prev_nxt = prev_r;
    mid_nxt  = mid_r;
    job_push = 1'b0;
    job      = '0;
    if (acc) begin
      if (!held_r) begin
        if (in_last_row) begin
          // single-row grid: one result, dead rows around it
          job_push = 1'b1;
          job.here = cur;
          job.done = 1'b1;
        end else begin
          held_nxt = 1'b1;
          prev_nxt = '0;
          mid_nxt  = cur;
        end
      end else begin
        job_push    = 1'b1;
        job.above   = prev_r;
        job.here    = mid_r;
        job.below   = cur;
        job.second  = in_last_row;
        if (in_last_row) begin
          held_nxt = 1'b0;
          prev_nxt = '0;
          mid_nxt  = '0;
        end else begin
          prev_nxt = mid_r;
          mid_nxt  = cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      prev_r <= '0;
      mid_r  <= '0;
    end else begin
      held_r <= held_nxt;
      prev_r <= prev_nxt;
      mid_r  <= mid_nxt;
    end
  end

endmodule

### rtl/lrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_queue
// Short request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module lrs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  lrs_pkg::job_t  wr_job,
  input  logic           rd_en,
  output lrs_pkg::job_t  rd_job,
  output logic           q_full,
  output logic           q_empty
);

  localparam int unsigned LAST = lrs_pkg::QDEPTH - 1;

  lrs_pkg::job_t                mem_r [lrs_pkg::QDEPTH];
  logic [lrs_pkg::QA_W-1:0]     wp_r, wp_nxt;
  logic [lrs_pkg::QA_W-1:0]     rp_r, rp_nxt;
  logic [lrs_pkg::QA_W:0]       cnt_r, cnt_nxt;
  logic                         do_wr, do_rd;

  assign q_full  = (cnt_r == (lrs_pkg::QA_W+1)'(lrs_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = mem_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == lrs_pkg::QA_W'(LAST)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == lrs_pkg::QA_W'(LAST)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

### rtl/lrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_back
// Computes one next-generation row per cycle from the queue head, while the
// output register is free or being popped, and holds it there until popped.
// ----------------------------------------------------------------------------
module lrs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lrs_pkg::job_t  head,
  input  lrs_pkg::row_t  mask,
  input  logic           pop,
  output logic           q_pop,
  output logic           empty,
  output lrs_pkg::row_t  out_next_row_bits,
  output logic           out_frame_done
);

  logic          phase_r, phase_nxt;
  logic          vld_r, vld_nxt;
  lrs_pkg::row_t data_r, data_nxt;
  logic          done_r, done_nxt;
  logic          load;
  logic          taken;

  assign taken = pop && vld_r;
  assign load  = !q_empty && (!vld_r || taken);
  assign q_pop = load && (phase_r || !head.second);

  // phase 0: middle row result, phase 1: final row result
  always_comb begin
    phase_nxt = phase_r;
    vld_nxt   = vld_r;
    data_nxt  = data_r;
    done_nxt  = done_r;
    if (taken) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
      if (phase_r) begin
        data_nxt  = lrs_pkg::next_gen(head.here, head.below, '0, mask);
        done_nxt  = 1'b1;
        phase_nxt = 1'b0;
      end else begin
        data_nxt  = lrs_pkg::next_gen(head.above, head.here, head.below, mask);
        done_nxt  = head.done;
        phase_nxt = head.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r   <= vld_nxt;
    end
    data_r <= data_nxt;
    done_r <= done_nxt;
  end

  assign empty             = !vld_r;
  assign out_next_row_bits = data_r;
  assign out_frame_done    = done_r;

endmodule

### rtl/life_automaton_row_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_row_step_unit
// One generation of a B3/S23 life grid, streamed one row per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_row_bits/in_last_row with push; a row is taken
//   when push is high and full is low. Mark the grid's final row with
//   in_last_row.
//   Result queue side: while empty is low the oldest result is shown on
//   out_next_row_bits/out_frame_done; pop takes it.
//   The first row of a grid gives no result unless it is also the final row;
//   each later row gives the result of the row before it, and the final row
//   adds its own result with out_frame_done set.
//   A released result is written into the request queue and then into the
//   output register, where it shows once that register is free.
//   Throughput: one row per cycle while full is low; a final row gives two
//   results, which the back computes one after the other, so a grid of N
//   rows gives N results. The two-entry request queue absorbs that.
//   Stalls: when pop is held low the output register holds, the queue fills,
//   and full rises; nothing is dropped.
//   Reset: queue, row window and output valid flag are cleared; cols_in_use
//   returns to 64. Column count is written over the APB port at addresses 0
//   to 3 (paddr[2] low); the user must write it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module life_automaton_row_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input queue
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_row_bits,
  input  logic        in_last_row,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_next_row_bits,
  output logic        out_frame_done,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_COLS = 1'b0;   // word index of cols_in_use

  lrs_pkg::cnt_t cols_r, cols_nxt;
  lrs_pkg::row_t mask;
  lrs_pkg::job_t job;
  lrs_pkg::job_t head;
  logic          job_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COLS);

  always_comb begin
    cols_nxt = cols_r;
    if (cfg_wr) begin
      cols_nxt = pwdata[lrs_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= lrs_pkg::cnt_t'(lrs_pkg::COLS);
    end else begin
      cols_r <= cols_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? {(32 - lrs_pkg::CNT_W)'(0), cols_r} : '0;
  assign mask   = lrs_pkg::active_mask(cols_r);
  assign full   = q_full;

  lrs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .q_full      (q_full),
    .in_row_bits (in_row_bits),
    .in_last_row (in_last_row),
    .mask        (mask),
    .job_push    (job_push),
    .job         (job)
  );

  lrs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job),
    .rd_en   (q_pop),
    .rd_job  (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  lrs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .head              (head),
    .mask              (mask),
    .pop               (pop),
    .q_pop             (q_pop),
    .empty             (empty),
    .out_next_row_bits (out_next_row_bits),
    .out_frame_done    (out_frame_done)
  );

endmodule

### rtl/lrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks for the row step unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "life_automaton_row_step_unit_assert.svh"

module lrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [63:0] out_next_row_bits,
  input logic        out_frame_done,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // nothing waits and nothing blocks right after reset
  `LRS_ASSERT_RST(a_rst_empty, clk, !$past(rst_n) |-> (empty && !full), "not clear after reset")

  // a stalled result holds its value
  `LRS_ASSERT(a_out_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_next_row_bits) && $stable(out_frame_done)), "stalled result changed")

  // column count readback follows the last write
  `LRS_ASSERT(a_cfg_rb, clk, rst_n, (psel && penable && pwrite && !paddr[2]) |=> (prdata[6:0] == $past(pwdata[6:0]) || paddr[2]), "column count readback wrong")

endmodule

bind life_automaton_row_step_unit lrs_checker u_lrs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_next_row_bits (out_next_row_bits),
  .out_frame_done    (out_frame_done),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite),
  .paddr             (paddr),
  .pwdata            (pwdata),
  .prdata            (prdata)
);

### tb/sv/life_automaton_row_step_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_row_step_unit_tb
// Self-checking bench for the streamed B3/S23 life row step unit.
// Rows are fed through the input queue side by a clocked driver. A local
// predictor keeps its own row window and column count and computes every
// next-generation row. A clocked monitor pops results and compares them in
// order. The column count is rewritten over APB between phases, also in the
// middle of an open grid. Idling on both sides changes from phase to phase,
// and one long pop stall lets the unit fill up and raise full.
// ----------------------------------------------------------------------------
module life_automaton_row_step_unit_tb;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 7;
  localparam int SETTLE       = 8;        // cycles after the last result
  localparam int HOLD_CYCLES  = 250;      // long pop stall
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ROWS   = 96;

  // APB register map
  localparam logic [2:0] ADDR_COLS   = 3'd0;
  localparam logic [2:0] ADDR_SPARE  = 3'd4;  // no register there

  typedef struct {
    lrs_pkg::row_t bits;
    logic          last;
  } row_req_t;

  typedef struct {
    lrs_pkg::row_t bits;
    logic          done;
  } gen_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] in_row_bits = '0;
  logic        in_last_row = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_next_row_bits;
  logic        out_frame_done;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // stimulus and expectations
  row_req_t row_backlog[$];
  gen_row_t gen_due[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 28;
  int       recv_idle_pct = 60;
  logic     hold_arm = 1'b0;
  logic     hold_taken = 1'b0;
  int       hold_left = 0;
  int       grid_rows_left = 0;

  // predictor state
  lrs_pkg::cnt_t col_count = lrs_pkg::cnt_t'(64);
  lrs_pkg::row_t win_above = '0;
  lrs_pkg::row_t win_middle = '0;
  int            win_rows = 0;

  row_req_t drv_next;
  gen_row_t mon_want;

  life_automaton_row_step_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_row_bits       (in_row_bits),
    .in_last_row       (in_last_row),
    .empty             (empty),
    .pop               (pop),
    .out_next_row_bits (out_next_row_bits),
    .out_frame_done    (out_frame_done),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  // Column i is live when i is below the count; counts above 64 saturate.
  function automatic lrs_pkg::row_t live_cols(input lrs_pkg::cnt_t n);
    lrs_pkg::row_t m;
    for (int i = 0; i < lrs_pkg::COLS; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  // Neighbor sums from shifted copies: <<1 brings column c-1 to c, >>1 c+1.
  function automatic lrs_pkg::row_t evolve(input lrs_pkg::row_t up,
                                           input lrs_pkg::row_t mid,
                                           input lrs_pkg::row_t dn,
                                           input lrs_pkg::row_t m);
    lrs_pkg::row_t up_w;
    lrs_pkg::row_t up_e;
    lrs_pkg::row_t mid_w;
    lrs_pkg::row_t mid_e;
    lrs_pkg::row_t dn_w;
    lrs_pkg::row_t dn_e;
    lrs_pkg::row_t nxt;
    int            n;
    up_w  = up << 1;
    up_e  = up >> 1;
    mid_w = mid << 1;
    mid_e = mid >> 1;
    dn_w  = dn << 1;
    dn_e  = dn >> 1;
    for (int c = 0; c < lrs_pkg::COLS; c++) begin
      n = int'(up_w[c]) + int'(up[c]) + int'(up_e[c])
        + int'(mid_w[c]) + int'(mid_e[c])
        + int'(dn_w[c]) + int'(dn[c]) + int'(dn_e[c]);
      nxt[c] = (n == 3) || (mid[c] && (n == 2));
    end
    return nxt & m;
  endfunction

  function automatic gen_row_t mk_result(input lrs_pkg::row_t bits, input logic done);
    gen_row_t r;
    r.bits = bits;
    r.done = done;
    return r;
  endfunction

  // One accepted row: slide the window and queue the rows it releases.
  task automatic predict_row_step(input lrs_pkg::row_t bits, input logic last);
    lrs_pkg::row_t m;
    lrs_pkg::row_t cur;
    m   = live_cols(col_count);
    cur = bits & m;
    if (win_rows == 0) begin
      if (last) begin
        gen_due.push_back(mk_result(evolve('0, cur, '0, m), 1'b1));
      end else begin
        win_above  = '0;
        win_middle = cur;
        win_rows   = 1;
      end
    end else begin
      gen_due.push_back(mk_result(evolve(win_above, win_middle, cur, m), 1'b0));
      if (last) begin
        gen_due.push_back(mk_result(evolve(win_middle, cur, '0, m), 1'b1));
        win_above  = '0;
        win_middle = '0;
        win_rows   = 0;
      end else begin
        win_above  = win_middle;
        win_middle = cur;
        win_rows   = 2;
      end
    end
  endtask

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_row_step(in_row_bits, in_last_row);
      end
      // hold a refused request, else offer the next row or idle
      if (!push || !full) begin
        if (row_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_next    = row_backlog.pop_front();
          push        <= 1'b1;
          in_row_bits <= drv_next.bits;
          in_last_row <= drv_next.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (gen_due.size() == 0) begin
          $display("%0t: unexpected result next_row_bits=%h frame_done=%b",
                   $time, out_next_row_bits, out_frame_done);
          fail_count++;
        end else begin
          mon_want = gen_due.pop_front();
          if (out_next_row_bits !== mon_want.bits) begin
            $display("%0t: next_row_bits mismatch expected %h actual %h",
                     $time, mon_want.bits, out_next_row_bits);
            fail_count++;
          end
          if (out_frame_done !== mon_want.done) begin
            $display("%0t: frame_done mismatch expected %b actual %b",
                     $time, mon_want.done, out_frame_done);
            fail_count++;
          end
        end
      end
      // one long stall when armed, random pops otherwise
      if (hold_arm && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        pop        <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ----------------------------------------------------------------- timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, gen_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic queue_row(input lrs_pkg::row_t bits, input logic last);
    row_req_t r;
    r.bits = bits;
    r.last = last;
    row_backlog.push_back(r);
  endtask

  // APB write: setup, access, register taken on the edge with pready high
  task automatic cfg_write(input logic [2:0] addr, input logic [6:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & 32'hFFFF_FF80) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_COLS) begin
      col_count = value;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every row is taken and every result popped, then settle.
  task automatic drain;
    do @(negedge clk);
    while (row_backlog.size() != 0 || push || gen_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly well-formed grids of random height; a few stray last_row flags.
  task automatic queue_random_rows(input int count);
    lrs_pkg::row_t bits;
    logic          last;
    for (int k = 0; k < count; k++) begin
      if (grid_rows_left == 0) begin
        grid_rows_left = ($urandom_range(99) < 80) ? $urandom_range(1, 12)
                                                    : $urandom_range(13, 40);
      end
      case ($urandom_range(9))
        0:       bits = '0;
        1:       bits = '1;
        2, 3, 4: bits = {$urandom(), $urandom()} & {$urandom(), $urandom()}
                      & {$urandom(), $urandom()};
        5, 6:    bits = {$urandom(), $urandom()} | {$urandom(), $urandom()};
        default: bits = {$urandom(), $urandom()};
      endcase
      last = (grid_rows_left == 1);
      if ($urandom_range(99) < 5) begin
        last = ~last;
      end
      grid_rows_left = last ? 0 : grid_rows_left - 1;
      queue_row(bits, last);
    end
  endtask

  initial begin
    lrs_pkg::cnt_t cfg_plan[12];

    rst_n = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-row grids, full width
    queue_row('1, 1'b1);
    queue_row(64'h0000_0007_0000_0000, 1'b1);
    // three rows: two of stripes and a full row
    queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_row(64'h5555_5555_5555_5555, 1'b0);
    queue_row('1, 1'b1);
    // vertical blinker
    queue_row(64'h0000_0001_0000_0000, 1'b0);
    queue_row(64'h0000_0001_0000_0000, 1'b0);
    queue_row(64'h0000_0001_0000_0000, 1'b1);
    // life on both edge columns, then a grid left open
    queue_row(64'h8000_0000_0000_0001, 1'b0);
    queue_row(64'hC000_0000_0000_0003, 1'b0);
    queue_row(64'h8000_0000_0000_0001, 1'b1);
    queue_row('1, 1'b0);
    queue_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
    drain();

    // narrow the grid while rows are held
    cfg_write(ADDR_COLS, 7'd5);
    queue_row('1, 1'b0);
    queue_row('1, 1'b1);
    drain();

    // no active columns
    cfg_write(ADDR_COLS, 7'd0);
    queue_row('1, 1'b0);
    queue_row('1, 1'b1);
    drain();

    // one column
    cfg_write(ADDR_COLS, 7'd1);
    queue_row('1, 1'b1);
    queue_row('1, 1'b0);
    queue_row('1, 1'b0);
    queue_row('1, 1'b1);
    drain();

    // count above the widest row saturates; spare address is ignored
    cfg_write(ADDR_COLS, 7'd127);
    cfg_write(ADDR_SPARE, 7'd3);
    queue_row('1, 1'b0);
    queue_row({$urandom(), $urandom()}, 1'b0);
    queue_row('1, 1'b1);
    drain();

    // random part: three idling patterns, four column counts each
    cfg_plan = '{lrs_pkg::cnt_t'(64), lrs_pkg::cnt_t'($urandom_range(2, 63)),
                 lrs_pkg::cnt_t'(0), lrs_pkg::cnt_t'($urandom_range(65, 127)),
                 lrs_pkg::cnt_t'(64), lrs_pkg::cnt_t'(1),
                 lrs_pkg::cnt_t'($urandom_range(2, 63)), lrs_pkg::cnt_t'(127),
                 lrs_pkg::cnt_t'(64), lrs_pkg::cnt_t'(63),
                 lrs_pkg::cnt_t'($urandom_range(2, 63)), lrs_pkg::cnt_t'(64)};
    for (int ph = 0; ph < 12; ph++) begin
      cfg_write(ADDR_COLS, cfg_plan[ph]);
      @(posedge clk);
      case (ph / 4)
        0: begin
          send_idle_pct <= 28;
          recv_idle_pct <= 60;
        end
        1: begin
          send_idle_pct <= 60;
          recv_idle_pct <= 28;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
          if (ph == 8) begin
            hold_arm <= 1'b1;
          end
        end
      endcase
      @(negedge clk);
      queue_random_rows(PHASE_ROWS);
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### life_automaton_row_step_unit.f
+incdir+rtl
rtl/lrs_pkg.sv
rtl/lrs_front.sv
rtl/lrs_queue.sv
rtl/lrs_back.sv
rtl/life_automaton_row_step_unit.sv
rtl/lrs_checker.sv
tb/sv/life_automaton_row_step_unit_tb.sv
